/* hdl/cmhp_pkg.sv */
// shared types and constants for the chunked map header parser
package cmhp_pkg;

   localparam logic [31:0] MAGIC_MPHD = 32'h4D504844;
   localparam logic [31:0] MAGIC_MAIN = 32'h4D41494E;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      KIND_FLAGS = 2'd0,
      KIND_TILE  = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_SKIP = 2'd0,
      CLASS_MPHD = 2'd1,
      CLASS_MAIN = 2'd2
   } chunk_class_type;

   // one queue entry: everything one byte causes
   typedef struct packed {
      logic        prim_valid;
      logic        prim_tile;
      logic [31:0] flags;
      logic [5:0]  tile_x;
      logic [5:0]  tile_y;
      logic        tile_exists;
      logic        done;
      logic        parse_valid;
   } entry_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

/* hdl/chunked_map_header_parser.sv */
// top level of the chunked map header parser
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata[7:0] data_byte
//  rsp     | out       | rsp_tvalid/tready    | tdata fields, tuser kind, tlast last_result
//  csr     | in        | csr_we               | csr_wdata file_length
//
//  one byte is taken per cycle while the entry queue has room; results pass
//  through the entry queue and the sequencer's output register before rsp
//  a byte that ends the file behind a flags or tile result gives two words,
//  which the sequencer sends one after the other from a single queue entry
//  reset is synchronous and active high; it clears the length and parse state
//  rsp stalls back up into the four-entry queue, then req_tready drops
module chunked_map_header_parser #(
   parameter int GRID_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: file length in bytes, also restarts the parse
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [31:0] flags_value, [32] big_alpha, [38:33] tile_x,
                                     // [44:39] tile_y, [45] tile_exists, [46] parse_valid
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast     // last_result
);

   cmhp_pkg::entry_type        front_entry;
   cmhp_pkg::entry_type        head_entry;
   cmhp_pkg::queue_status_type q_status;
   logic accept, push, pop;

   // byte taken only while the queue can hold whatever it causes
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   cmhp_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .data_byte (req_tdata),
      .push      (push),
      .entry     (front_entry)
   );

   cmhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   cmhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_status.valid),
      .q_entry    (head_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hdl/cmhp_front.sv */
// front end: takes file bytes, walks chunk headers and builds result entries
module cmhp_front #(
   parameter int GRID_SIDE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [31:0]         csr_wdata,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   output logic                push,
   output cmhp_pkg::entry_type entry
);

   localparam int XW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int YW = $clog2(GRID_SIDE + 1);
   localparam logic [31:0] TABLE_BYTES = 32'(GRID_SIDE * GRID_SIDE * 8);
   localparam logic [XW-1:0] X_LAST = XW'(GRID_SIDE - 1);
   localparam logic [YW-1:0] Y_END  = YW'(GRID_SIDE);

   logic [31:0] file_length_ff, file_length_in;
   logic [31:0] left_ff, left_in;
   logic [3:0]  hcount_ff, hcount_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] offset_ff, offset_in;
   cmhp_pkg::chunk_class_type class_ff, class_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] flags_ff, flags_in;
   logic [XW-1:0] tx_ff, tx_in;
   logic [YW-1:0] ty_ff, ty_in;

   logic [31:0] size_full;

   always_comb begin
      file_length_in = file_length_ff;
      left_in        = left_ff;
      hcount_in      = hcount_ff;
      magic_in       = magic_ff;
      size_in        = size_ff;
      offset_in      = offset_ff;
      class_in       = class_ff;
      stopped_in     = stopped_ff;
      flags_in       = flags_ff;
      tx_in          = tx_ff;
      ty_in          = ty_ff;
      entry          = '0;
      size_full      = {data_byte, size_ff[23:0]};

      if (csr_we) begin
         file_length_in = csr_wdata;
         left_in        = csr_wdata - 32'd1;
         hcount_in      = '0;
         magic_in       = '0;
         size_in        = '0;
         offset_in      = '0;
         class_in       = cmhp_pkg::CLASS_SKIP;
         stopped_in     = 1'b0;
         flags_in       = '0;
         tx_in          = '0;
         ty_in          = '0;
      end else if (accept && file_length_ff != 32'd0) begin
         if (!stopped_ff) begin
            if (!hcount_ff[3]) begin
               // header bytes
               if (!hcount_ff[2]) begin
                  magic_in[8*hcount_ff[1:0] +: 8] = data_byte;
               end else begin
                  size_in[8*hcount_ff[1:0] +: 8] = data_byte;
               end
               hcount_in = hcount_ff + 4'd1;
               if (hcount_ff == 4'd7) begin
                  if (size_full > left_ff) begin
                     stopped_in = 1'b1;
                  end else begin
                     offset_in = '0;
                     tx_in     = '0;
                     ty_in     = '0;
                     if (magic_ff == cmhp_pkg::MAGIC_MPHD && size_full >= 32'd4) begin
                        class_in = cmhp_pkg::CLASS_MPHD;
                     end else if (magic_ff == cmhp_pkg::MAGIC_MAIN
                                  && size_full >= TABLE_BYTES) begin
                        class_in = cmhp_pkg::CLASS_MAIN;
                     end else begin
                        class_in = cmhp_pkg::CLASS_SKIP;
                     end
                     if (size_full == 32'd0) begin
                        hcount_in = '0;
                        magic_in  = '0;
                     end
                  end
               end
            end else begin
               // body bytes
               if (class_ff == cmhp_pkg::CLASS_MPHD && offset_ff < 32'd4) begin
                  flags_in[8*offset_ff[1:0] +: 8] = data_byte;
                  if (offset_ff[1:0] == 2'd3) begin
                     entry.prim_valid = 1'b1;
                     entry.prim_tile  = 1'b0;
                  end
               end else if (class_ff == cmhp_pkg::CLASS_MAIN && offset_ff[2:0] == 3'd0
                            && ty_ff < Y_END) begin
                  entry.prim_valid  = 1'b1;
                  entry.prim_tile   = 1'b1;
                  entry.tile_x      = 6'(tx_ff);
                  entry.tile_y      = 6'(ty_ff);
                  entry.tile_exists = data_byte[0];
                  if (tx_ff == X_LAST) begin
                     tx_in = '0;
                     ty_in = ty_ff + YW'(1);
                  end else begin
                     tx_in = tx_ff + XW'(1);
                  end
               end
               if ({1'b0, offset_ff} + 33'd1 == {1'b0, size_ff}) begin
                  hcount_in = '0;
                  magic_in  = '0;
                  size_in   = '0;
                  offset_in = '0;
                  class_in  = cmhp_pkg::CLASS_SKIP;
               end else begin
                  offset_in = offset_ff + 32'd1;
               end
            end
         end

         // done and flags words report the flags after this byte's update
         entry.flags = flags_in;

         if (left_ff == 32'd0) begin
            entry.done        = 1'b1;
            entry.parse_valid = (file_length_ff >= 32'd8);
            left_in    = file_length_ff - 32'd1;
            hcount_in  = '0;
            magic_in   = '0;
            size_in    = '0;
            offset_in  = '0;
            class_in   = cmhp_pkg::CLASS_SKIP;
            stopped_in = 1'b0;
            flags_in   = '0;
            tx_in      = '0;
            ty_in      = '0;
         end else begin
            left_in = left_ff - 32'd1;
         end
      end
   end

   assign push = accept && file_length_ff != 32'd0 && !csr_we
                 && (entry.prim_valid || entry.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
         left_ff        <= '1;
         hcount_ff      <= '0;
         magic_ff       <= '0;
         size_ff        <= '0;
         offset_ff      <= '0;
         class_ff       <= cmhp_pkg::CLASS_SKIP;
         stopped_ff     <= 1'b0;
         flags_ff       <= '0;
         tx_ff          <= '0;
         ty_ff          <= '0;
      end else begin
         file_length_ff <= file_length_in;
         left_ff        <= left_in;
         hcount_ff      <= hcount_in;
         magic_ff       <= magic_in;
         size_ff        <= size_in;
         offset_ff      <= offset_in;
         class_ff       <= class_in;
         stopped_ff     <= stopped_in;
         flags_ff       <= flags_in;
         tx_ff          <= tx_in;
         ty_ff          <= ty_in;
      end
   end

endmodule

/* hdl/cmhp_queue.sv */
// short entry queue between the byte walker and the result sequencer
module cmhp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmhp_pkg::entry_type        push_entry,
   input  logic                       pop,
   output cmhp_pkg::entry_type        head_entry,
   output cmhp_pkg::queue_status_type status
);

   cmhp_pkg::entry_type slot_ff [cmhp_pkg::QUEUE_DEPTH];
   logic [cmhp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cmhp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cmhp_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic do_pop;

   assign status.full  = (count_ff == (cmhp_pkg::QUEUE_AW + 1)'(cmhp_pkg::QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (cmhp_pkg::QUEUE_AW + 1)'(push)
                  - (cmhp_pkg::QUEUE_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/cmhp_back.sv */
// back end: turns queue entries into one or two result words
module cmhp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  cmhp_pkg::entry_type                 q_entry,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cmhp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   cmhp_pkg::entry_type ent_ff, ent_in;
   logic valid_ff, valid_in;
   logic second_ff, second_in;
   logic show_prim, final_word, take, load;
   logic [31:0] flags;
   logic        big_alpha;

   assign show_prim  = ent_ff.prim_valid && !second_ff;
   assign final_word = !(show_prim && ent_ff.done);
   assign take       = valid_ff && rsp_tready;
   assign load       = !valid_ff || (take && final_word);
   assign q_pop      = load && q_valid;

   always_comb begin
      if (show_prim && ent_ff.prim_tile) begin
         rsp_tuser = cmhp_pkg::KIND_TILE;
         flags     = '0;
         big_alpha = 1'b0;
         rsp_tdata = {1'b0, 1'b0, ent_ff.tile_exists, ent_ff.tile_y, ent_ff.tile_x,
                      big_alpha, flags};
      end else if (show_prim) begin
         rsp_tuser = cmhp_pkg::KIND_FLAGS;
         flags     = ent_ff.flags;
         big_alpha = ent_ff.flags[2];
         rsp_tdata = {1'b0, 1'b0, 1'b0, 6'd0, 6'd0, big_alpha, flags};
      end else begin
         rsp_tuser = cmhp_pkg::KIND_DONE;
         flags     = ent_ff.flags;
         big_alpha = ent_ff.flags[2];
         rsp_tdata = {1'b0, ent_ff.parse_valid, 1'b0, 6'd0, 6'd0, big_alpha, flags};
      end
      rsp_tlast  = final_word;
      rsp_tvalid = valid_ff;
   end

   always_comb begin
      ent_in    = ent_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (take && !final_word) begin
         second_in = 1'b1;
      end
      if (load) begin
         valid_in  = q_valid;
         ent_in    = q_entry;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

endmodule

/* verif/tb.sv */
// self-checking testbench for the chunked map header parser
`timescale 1ns / 1ps

module tb;

   localparam int GRID_SIDE    = 64;
   localparam int TABLE_BYTES  = GRID_SIDE * GRID_SIDE * 8;
   localparam int RESET_CYCLES = 12;
   // quiet cycles after the last expected result before a register write
   localparam int HOLD_OFF     = 16;
   // longest stretch with no handshake anywhere before the run is declared hung
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 850;

   // one result word as the predictor sees it
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] flags_value;
      logic        big_alpha;
      logic [5:0]  tile_x;
      logic [5:0]  tile_y;
      logic        tile_exists;
      logic        parse_valid;
      logic        last_result;
   } parse_result_type;

   // every input is known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [31:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // predictor copy of the parse state
   logic [31:0]               file_len     = '0;
   logic [31:0]               byte_pos     = '0;
   int unsigned               hdr_taken    = 0;
   logic [31:0]               magic_acc    = '0;
   logic [31:0]               size_acc     = '0;
   logic [31:0]               body_off     = '0;
   cmhp_pkg::chunk_class_type body_class   = cmhp_pkg::CLASS_SKIP;
   logic                      parse_halted = 1'b0;
   logic [31:0]               flags_seen   = '0;

   parse_result_type pending_results[$];
   logic [7:0]       file_image[$];
   int               error_count  = 0;
   int               quiet_cycles = 0;
   int               bytes_parsed = 0;
   int               burst_left   = 0;

   always #5 clock = ~clock;

   chunked_map_header_parser #(
      .GRID_SIDE (GRID_SIDE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [7:0] data_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [31:0] flags_value, [32] big_alpha, [38:33] tile_x,
                                   // [44:39] tile_y, [45] tile_exists, [46] parse_valid
      .rsp_tuser  (rsp_tuser),     // [1:0] kind
      .rsp_tlast  (rsp_tlast)      // last_result
   );

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic void clear_parse_state();
      byte_pos     = '0;
      hdr_taken    = 0;
      magic_acc    = '0;
      size_acc     = '0;
      body_off     = '0;
      body_class   = cmhp_pkg::CLASS_SKIP;
      parse_halted = 1'b0;
      flags_seen   = '0;
   endfunction

   function automatic parse_result_type make_result(input cmhp_pkg::kind_type kind,
                                                    input logic [31:0] flags,
                                                    input logic [5:0] tx, input logic [5:0] ty,
                                                    input logic ex, input logic pv);
      parse_result_type r;
      r.kind        = kind;
      r.flags_value = flags;
      r.big_alpha   = (kind == cmhp_pkg::KIND_TILE) ? 1'b0 : flags[2];
      r.tile_x      = tx;
      r.tile_y      = ty;
      r.tile_exists = ex;
      r.parse_valid = pv;
      r.last_result = 1'b0;
      return r;
   endfunction

   // walks one file byte through the chunk state and queues what it causes
   function automatic void parse_byte_results(input logic [7:0] b);
      parse_result_type caused[$];
      logic [63:0]      bytes_left;
      logic [31:0]      entry;
      if (file_len == 0) return;
      if (!parse_halted) begin
         if (hdr_taken < 8) begin
            // header: magic then size, both little-endian
            if (hdr_taken < 4) magic_acc |= {24'd0, b} << (8 * hdr_taken);
            else size_acc |= {24'd0, b} << (8 * (hdr_taken - 4));
            hdr_taken++;
            if (hdr_taken == 8) begin
               bytes_left = {32'd0, file_len} - {32'd0, byte_pos} - 64'd1;
               if ({32'd0, size_acc} > bytes_left) begin
                  // body would run past the file end
                  parse_halted = 1'b1;
               end else begin
                  body_off = '0;
                  if (magic_acc == cmhp_pkg::MAGIC_MPHD && size_acc >= 4)
                     body_class = cmhp_pkg::CLASS_MPHD;
                  else if (magic_acc == cmhp_pkg::MAGIC_MAIN && size_acc >= TABLE_BYTES)
                     body_class = cmhp_pkg::CLASS_MAIN;
                  else body_class = cmhp_pkg::CLASS_SKIP;
                  if (size_acc == 0) begin
                     hdr_taken = 0;
                     magic_acc = '0;
                  end
               end
            end
         end else begin
            if (body_class == cmhp_pkg::CLASS_MPHD && body_off < 4) begin
               flags_seen[8 * body_off +: 8] = b;
               if (body_off == 3)
                  caused.push_back(make_result(cmhp_pkg::KIND_FLAGS, flags_seen, '0, '0,
                                               1'b0, 1'b0));
            end else if (body_class == cmhp_pkg::CLASS_MAIN && body_off[2:0] == 3'd0) begin
               entry = body_off >> 3;
               if (entry < GRID_SIDE * GRID_SIDE)
                  caused.push_back(make_result(cmhp_pkg::KIND_TILE, '0,
                                               6'(entry % GRID_SIDE),
                                               6'(entry / GRID_SIDE), b[0], 1'b0));
            end
            if ({32'd0, body_off} + 64'd1 >= {32'd0, size_acc}) begin
               hdr_taken  = 0;
               magic_acc  = '0;
               size_acc   = '0;
               body_off   = '0;
               body_class = cmhp_pkg::CLASS_SKIP;
            end else begin
               body_off++;
            end
         end
      end
      // final byte of the file: done word, then the next file starts over
      if ({32'd0, byte_pos} + 64'd1 >= {32'd0, file_len}) begin
         caused.push_back(make_result(cmhp_pkg::KIND_DONE, flags_seen, '0, '0, 1'b0,
                                      file_len >= 8));
         clear_parse_state();
      end else begin
         byte_pos++;
      end
      if (caused.size() > 0) caused[caused.size() - 1].last_result = 1'b1;
      foreach (caused[i]) pending_results.push_back(caused[i]);
   endfunction

   // ---------------------------------------------------------------
   // result checking and watchdog
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // every accepted result word is matched against the oldest prediction
   always @(posedge clock) begin : result_check
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: kind %0d tdata 0x%0h",
                   rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("flags_value", want.flags_value, rsp_tdata[31:0]);
            check_field("big_alpha", 32'(want.big_alpha), 32'(rsp_tdata[32]));
            check_field("tile_x", 32'(want.tile_x), 32'(rsp_tdata[38:33]));
            check_field("tile_y", 32'(want.tile_y), 32'(rsp_tdata[44:39]));
            check_field("tile_exists", 32'(want.tile_exists), 32'(rsp_tdata[45]));
            check_field("parse_valid", 32'(want.parse_valid), 32'(rsp_tdata[46]));
            check_field("tdata_pad", 32'd0, 32'(rsp_tdata[47]));
            check_field("last_result", 32'(want.last_result), 32'(rsp_tlast));
         end
      end
   end

   // a run with no handshake for too long is hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: free-flowing stretches, random back-pressure and hard stalls
   initial begin : rsp_stall_pattern
      int mode;
      int run;
      forever begin
         mode = $urandom_range(0, 3);
         run  = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(1, 60);
         repeat (run) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers; each one starts and ends on a falling edge
   // ---------------------------------------------------------------

   // offer one byte, wait for it to be taken, then maybe open a gap
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (file_len != 0) bytes_parsed++;
      parse_byte_results(b);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(0, 12);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // hold the sender until every predicted word has arrived, then let the
   // pipeline empty of bytes that give no result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   // writing the length also restarts the parse
   task automatic set_file_length(input logic [31:0] len);
      wait_drained();
      csr_wdata <= len;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      file_len = len;
      clear_parse_state();
   endtask

   function automatic void push_le32(input logic [31:0] w);
      for (int i = 0; i < 4; i++) file_image.push_back(w[8 * i +: 8]);
   endfunction

   function automatic void push_header(input logic [31:0] magic, input logic [31:0] len);
      push_le32(magic);
      push_le32(len);
   endfunction

   function automatic void push_random(input int n);
      repeat (n) file_image.push_back(8'($urandom));
   endfunction

   // stream the built image; a pause index makes the sender wait for all results
   task automatic stream_image(input int pause_at);
      for (int i = 0; i < file_image.size(); i++) begin
         if (i == pause_at) wait_drained();
         send_byte(file_image[i]);
      end
   endtask

   // mostly well-formed chunk runs with random content, some noise and damage
   function automatic void build_random_image(input int len);
      int          pick;
      logic [31:0] chunk_len;
      logic [31:0] magic;
      file_image.delete();
      while (file_image.size() < len) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: begin
               chunk_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 12);
               push_header(cmhp_pkg::MAGIC_MPHD, chunk_len);
               push_random(chunk_len);
            end
            4: begin
               // one bit off the flags magic
               chunk_len = $urandom_range(0, 12);
               push_header(cmhp_pkg::MAGIC_MPHD ^ (32'd1 << $urandom_range(0, 31)), chunk_len);
               push_random(chunk_len);
            end
            5: begin
               chunk_len = $urandom_range(0, 16);
               push_header($urandom, chunk_len);
               push_random(chunk_len);
            end
            6: begin
               // tile magic but far too short for a table
               chunk_len = $urandom_range(0, 24);
               push_header(cmhp_pkg::MAGIC_MAIN, chunk_len);
               push_random(chunk_len);
            end
            7: push_header($urandom, 32'd0);
            8: begin
               // header whose body cannot fit
               case ($urandom_range(0, 2))
                  0: magic = cmhp_pkg::MAGIC_MPHD;
                  1: magic = cmhp_pkg::MAGIC_MAIN;
                  default: magic = $urandom;
               endcase
               push_header(magic, $urandom_range(256, 32'hFFFF_FFFF));
            end
            default: push_random($urandom_range(1, 5));
         endcase
      end
      // cutting to length leaves partial headers and overlong bodies
      while (file_image.size() > len) void'(file_image.pop_back());
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // no length set: every byte is dropped
   task automatic test_zero_length();
      set_file_length(32'd0);
      file_image.delete();
      file_image.push_back(8'h00);
      file_image.push_back(8'hFF);
      push_random(2);
      stream_image(-1);
   endtask

   // files below one header: only a done word, and the position wraps
   task automatic test_short_files();
      set_file_length(32'd1);
      file_image.delete();
      file_image.push_back(8'hA5);
      file_image.push_back(8'h5A);
      stream_image(-1);
      set_file_length(32'd7);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd4);
      void'(file_image.pop_back());
      stream_image(-1);
   endtask

   // flags chunk: flags and done on one byte, big alpha, a cut-off flags word
   task automatic test_flags_chunk();
      set_file_length(32'd12);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd4);
      push_le32(32'hFFFF_FFFF);
      stream_image(-1);
      set_file_length(32'd20);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd4);
      push_le32(32'h0000_0004);
      push_header(32'h4142_4344, 32'd0);
      stream_image(-1);
      set_file_length(32'd10);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd4);
      push_random(2);
      stream_image(-1);
   endtask

   // body that fills the file exactly, one byte too long, short flags chunk,
   // and a zero-size chunk followed by a header cut short
   task automatic test_chunk_limits();
      set_file_length(32'd20);
      file_image.delete();
      push_header(32'h1234_5678, 32'd12);
      push_random(12);
      stream_image(-1);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd13);
      push_random(12);
      stream_image(-1);
      set_file_length(32'd11);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd3);
      push_random(3);
      stream_image(-1);
      set_file_length(32'd13);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd0);
      push_random(5);
      stream_image(-1);
   endtask

   // largest length: a tile table header whose body just fits the file, then a
   // flags chunk one byte too long
   task automatic test_length_extremes();
      set_file_length(32'hFFFF_FFFF);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'd4);
      push_random(4);
      push_header(cmhp_pkg::MAGIC_MAIN, 32'hFFFF_FFEB);
      push_random(17);
      stream_image(-1);
      set_file_length(32'hFFFF_FFFF);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MPHD, 32'hFFFF_FFF8);
      push_random(4);
      stream_image(-1);
   endtask

   // one byte short of a tile table is skipped; a full-size table gives one
   // word per entry, across a row boundary
   task automatic test_tile_table();
      set_file_length(32'hFFFF_FFFF);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MAIN, 32'(TABLE_BYTES - 1));
      push_random(64);
      stream_image(-1);
      set_file_length(32'hFFFF_FFFF);
      file_image.delete();
      push_header(cmhp_pkg::MAGIC_MAIN, 32'(TABLE_BYTES));
      push_random(8 * (GRID_SIDE + 6));
      stream_image(-1);
   endtask

   // random files over many lengths, back-to-back files of one length,
   // and now and then a pause mid-file until all results are in
   task automatic test_random_files();
      int          start_count;
      int          pick;
      int          copies;
      int          pause_at;
      logic [31:0] len;
      start_count = bytes_parsed;
      while (bytes_parsed - start_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) len = 32'd0;
         else if (pick == 1) len = 32'hFFFF_FFFF;
         else if (pick == 2) len = $urandom;
         else if (pick < 5) len = $urandom_range(1, 7);
         else len = $urandom_range(8, 96);
         set_file_length(len);
         copies = (len > 0 && len <= 96) ? $urandom_range(1, 3) : 1;
         repeat (copies) begin
            build_random_image((len > 0 && len <= 96) ? int'(len) : $urandom_range(8, 64));
            pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, file_image.size() - 1)
                                                  : -1;
            stream_image(pause_at);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_zero_length();
      test_short_files();
      test_flags_chunk();
      test_chunk_limits();
      test_length_extremes();
      test_tile_table();
      test_random_files();
      // all results in, then a quiet stretch to catch stray words
      wait_drained();
      repeat (HOLD_OFF) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
